>>> rtl/tccs_pkg.sv
// Package for the toy counter stream cipher: field widths, register codes,
// item and configuration types, and the per-byte keystream functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tccs_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_INITIAL_KEY     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INITIAL_COUNTER = 1'd1;

   localparam logic [BYTE_W-1:0] KEY_RESET = 8'd178;
   localparam logic [BYTE_W-1:0] CTR_RESET = 8'd40;

   localparam logic [BYTE_W-1:0] MASK_EVEN = 8'h55;
   localparam logic [BYTE_W-1:0] MASK_ODD  = 8'hAA;
   localparam logic [BYTE_W-1:0] MASK_ALL  = 8'hFF;

   typedef struct packed {
      logic              valid;
      logic              restart;
      logic [BYTE_W-1:0] data;
   } tccs_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] initial_key;
      logic [BYTE_W-1:0] initial_counter;
   } tccs_cfg_type;

   // bits 7..0, each XORed with bit i+1 or i+2 mod 8 of the partly updated value
   function automatic logic [BYTE_W-1:0] scramble(input logic [BYTE_W-1:0] key,
                                                  input logic [BYTE_W-1:0] ctr);
      logic [BYTE_W-1:0] v;
      logic [2:0]        p;
      v = ctr;
      for (int i = 7; i >= 0; i--) begin
         p    = key[i] ? 3'(i + 1) : 3'(i + 2);
         v[i] = v[i] ^ v[p];
      end
      return v;
   endfunction

   // x mod 9 through a reciprocal multiply, exact for all byte values
   function automatic logic [3:0] mod9(input logic [BYTE_W-1:0] x);
      logic [15:0] prod;
      logic [4:0]  q;
      logic [7:0]  q9;
      prod = 16'(x) * 16'd57;
      q    = prod[13:9];
      q9   = 8'(q) * 8'd9;
      return 4'(x - q9);
   endfunction

   function automatic logic [BYTE_W-1:0] select_mask(input logic [3:0] r);
      logic [BYTE_W-1:0] m;
      if (r < 4'd3) begin
         m = MASK_EVEN;
      end else if (r < 4'd6) begin
         m = MASK_ODD;
      end else begin
         m = MASK_ALL;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

>>> rtl/tccs_if.sv
// Stream interfaces for the cipher's request and response channels.
// Depends on tccs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tccs_req_if;
   import tccs_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              restart;
   modport source (output valid, output data_byte, output restart, input ready);
   modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface tccs_rsp_if;
   import tccs_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] result_byte;
   modport source (output valid, output result_byte, input ready);
   modport sink   (input valid, input result_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/tccs_csr.sv
// Configuration registers: initial key and initial counter.
// Depends on tccs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tccs_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [tccs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tccs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output tccs_pkg::tccs_cfg_type                cfg
);
   import tccs_pkg::*;

   logic [BYTE_W-1:0] key_ff, key_in;
   logic [BYTE_W-1:0] ctr_ff, ctr_in;

   always_comb begin
      key_in = key_ff;
      ctr_in = ctr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_INITIAL_KEY:     key_in = csr_wdata;
            REG_INITIAL_COUNTER: ctr_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_RESET;
         ctr_ff <= CTR_RESET;
      end else begin
         key_ff <= key_in;
         ctr_ff <= ctr_in;
      end
   end

   assign cfg.initial_key     = key_ff;
   assign cfg.initial_counter = ctr_ff;

endmodule

`default_nettype wire

>>> rtl/tccs_in_reg.sv
// Input register stage: holds one accepted request item until the core takes it.
// Depends on tccs_pkg and tccs_if.
`timescale 1ns / 1ps
`default_nettype none

module tccs_in_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   tccs_req_if.sink                req,
   input  wire logic               advance,
   output tccs_pkg::tccs_item_type item
);
   import tccs_pkg::*;

   logic              valid_ff, valid_in;
   logic              restart_ff, restart_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in   = valid_ff;
      restart_in = restart_ff;
      data_in    = data_ff;
      if (take) begin
         valid_in   = 1'b1;
         restart_in = req.restart;
         data_in    = req.data_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      restart_ff <= restart_in;
      data_ff    <= data_in;
   end

   assign item.valid   = valid_ff;
   assign item.restart = restart_ff;
   assign item.data    = data_ff;

endmodule

`default_nettype wire

>>> rtl/tccs_core.sv
// Cipher core: running key and counter, per-byte keystream and the result register.
// Depends on tccs_pkg and tccs_if.
`timescale 1ns / 1ps
`default_nettype none

module tccs_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tccs_pkg::tccs_item_type item,
   input  wire tccs_pkg::tccs_cfg_type  cfg,
   output logic                   advance,
   tccs_rsp_if.source             rsp
);
   import tccs_pkg::*;

   logic [BYTE_W-1:0] key_ff, key_in;
   logic [BYTE_W-1:0] ctr_ff, ctr_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;
   logic [BYTE_W-1:0] key_cur, ctr_cur, ctr_new, mask;
   logic              fire;

   assign advance = !out_valid_ff || rsp.ready;
   assign fire    = item.valid && advance;

   assign key_cur = item.restart ? cfg.initial_key     : key_ff;
   assign ctr_cur = item.restart ? cfg.initial_counter : ctr_ff;
   assign ctr_new = scramble(key_cur, ctr_cur) + 8'd1;
   assign mask    = select_mask(mod9(ctr_new));

   always_comb begin
      key_in       = key_ff;
      ctr_in       = ctr_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (fire) begin
         key_in       = key_cur + 8'd1;
         ctr_in       = ctr_new;
         out_valid_in = 1'b1;
         out_data_in  = item.data ^ (ctr_new & mask);
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= KEY_RESET;
         ctr_ff       <= CTR_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         ctr_ff       <= ctr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.result_byte = out_data_ff;

endmodule

`default_nettype wire

>>> rtl/toy_counter_stream_cipher_top.sv
// Top level of the toy counter stream cipher.
// Depends on tccs_pkg, tccs_if, tccs_csr, tccs_in_reg and tccs_core.
//
// Usage:
//   req carries one byte (data_byte) and a restart flag per item; restart
//   reloads the running key and counter from the configuration registers
//   before that byte. rsp returns one result_byte per request item, in order.
//   Encryption and decryption are the same operation.
//   csr_wr_en/csr_index/csr_wdata write initial_key (index 0) and
//   initial_counter (index 1); write only while the block is idle.
//   Path: the accepting edge loads the input register; the result register
//   then loads through the keystream logic once the core may advance (rsp
//   empty or being taken).
//   Throughput: 1 item per cycle while rsp does not stall, set by the state
//   update of the running key and counter in the core.
//   Reset: running key 178, counter 40, both configuration registers the
//   same, no items held.
//   Stall: when rsp is not taken the result holds; one more item is taken
//   into the input register, then req.ready drops until rsp moves.
`timescale 1ns / 1ps
`default_nettype none

module toy_counter_stream_cipher_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   tccs_req_if.sink                              req,
   tccs_rsp_if.source                            rsp,
   input  wire logic                             csr_wr_en,
   input  wire logic [tccs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tccs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tccs_pkg::*;

   tccs_cfg_type  cfg;
   tccs_item_type item;
   logic          advance;

   tccs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tccs_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .advance (advance),
      .item    (item)
   );

   tccs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .cfg     (cfg),
      .advance (advance),
      .rsp     (rsp)
   );

endmodule

`default_nettype wire

>>> rtl/tccs_checker.sv
// Port-level checks for the cipher top level, bound onto it.
// Depends on tccs_pkg and toy_counter_stream_cipher_top.
`timescale 1ns / 1ps
`default_nettype none

module tccs_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [tccs_pkg::BYTE_W-1:0] rsp_result_byte
);
   import tccs_pkg::*;

   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not empty after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_byte)))
      else $error("stalled result changed or dropped");

   a_full_backpressure : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_valid && !rsp_ready) ##1 !rsp_ready
      |-> !req_ready)
      else $error("item taken while both stages full");

   a_drain_ready : assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side takes items");

endmodule

bind toy_counter_stream_cipher_top tccs_checker u_tccs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_result_byte (rsp.result_byte)
);

`default_nettype wire
